@@ rtl/wss_pkg.sv @@
`timescale 1ns / 1ps
// wss_pkg: widths, constants and controller/datapath command and status types
// for the windowed speed statistics block. No dependencies.
package wss_pkg;

    localparam int SAMPLE_W         = 32;
    localparam int WARMUP_W         = 16;
    localparam int SEEN_W           = WARMUP_W + 1;
    localparam int COUNT_W          = 32;
    localparam int TOTAL_W          = 64;
    localparam int DIV_W            = 32;
    localparam int DIV_CNT_W        = $clog2(DIV_W);
    localparam int OUT_TDATA_W      = 4 * SAMPLE_W;
    localparam int WINDOW_DEPTH_DEF = 16;

    localparam logic [SEEN_W-1:0] SEEN_MAX = SEEN_W'(1) << WARMUP_W;

    typedef struct packed {
        logic capture;
        logic update;
        logic div_start_w;
        logic div_start_o;
        logic cap_w;
        logic cap_o;
        logic load_out;
    } wss_cmd_t;

    typedef struct packed {
        logic w_empty;
        logic o_direct;
        logic div_done;
    } wss_status_t;

endpackage

@@ rtl/windowed_speed_statistics.sv @@
`timescale 1ns / 1ps
// windowed_speed_statistics: top level, controller plus datapath.
// Depends on wss_pkg, wss_ctrl, wss_dp (which holds wss_div).
//
//  channel   direction  signals                   contents
//  s_*       in         tvalid tready tdata[31:0] speed_sample (Q16.16)
//  m_*       out        tvalid tready tdata[127:0] tuser  means, min, max; warmup flag
//  cfg_*     in         we wdata[15:0]            warmup_samples
//
// One sample at a time; a mean needs the serial divider (start, 32 steps, done)
// unless the window is empty, or for the overall mean no sample is kept or it saturates.
// Reset clears all statistics and warmup_samples; the window ring needs no clearing.
// A result held in the output register does not stop the next sample from being
// taken; only its final load waits for m_tready.
module windowed_speed_statistics #(
    parameter int WINDOW_DEPTH = wss_pkg::WINDOW_DEPTH_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [wss_pkg::SAMPLE_W-1:0]      s_tdata,   // [31:0] speed_sample
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [31:0] window_mean, [63:32] overall_mean, [95:64] lowest_speed,
    // [127:96] highest_speed
    output logic [wss_pkg::OUT_TDATA_W-1:0]   m_tdata,
    output logic                              m_tuser,   // [0] warming_up
    input  logic                              cfg_we,
    input  logic [wss_pkg::WARMUP_W-1:0]      cfg_wdata  // warmup_samples
);
    import wss_pkg::*;

    wss_cmd_t    cmd;
    wss_status_t status;

    wss_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    wss_dp #(
        .WINDOW_DEPTH (WINDOW_DEPTH)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .sample_in (s_tdata),
        .cmd       (cmd),
        .status    (status),
        .out_data  (m_tdata),
        .out_warm  (m_tuser)
    );

endmodule

@@ rtl/wss_div.sv @@
`timescale 1ns / 1ps
// wss_div: restoring serial divider, one quotient bit per cycle.
// Needs dividend high word below the divisor. Depends on wss_pkg.
module wss_div (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [wss_pkg::DIV_W-1:0]    num_hi,
    input  logic [wss_pkg::DIV_W-1:0]    num_lo,
    input  logic [wss_pkg::DIV_W-1:0]    den,
    output logic                         done,
    output logic [wss_pkg::DIV_W-1:0]    quotient
);
    import wss_pkg::*;

    logic [DIV_W-1:0]     rem_reg, rem_next;
    logic [DIV_W-1:0]     quo_reg, quo_next;
    logic [DIV_W-1:0]     den_reg;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_W:0]       shifted;
    logic [DIV_W:0]       diff;
    logic                 ge;

    always_comb
    begin
        shifted = {rem_reg, quo_reg[DIV_W-1]};
        diff    = shifted - {1'b0, den_reg};
        ge      = shifted >= {1'b0, den_reg};
    end

    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = num_hi;
            quo_next  = num_lo;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? diff[DIV_W-1:0] : shifted[DIV_W-1:0];
            quo_next = {quo_reg[DIV_W-2:0], ge};
            cnt_next = cnt_reg + DIV_CNT_W'(1);
            if (cnt_reg == DIV_CNT_W'(DIV_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        if (start)
            den_reg <= den;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

    a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> !busy_reg)
        else $error("divider started while busy");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !busy_reg)
        else $error("divider done while still busy");

    a_last_step: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && !start && cnt_reg == DIV_CNT_W'(DIV_W - 1)) |=> done_reg)
        else $error("divider missed its done pulse");

endmodule

@@ rtl/wss_ctrl.sv @@
`timescale 1ns / 1ps
// wss_ctrl: sequencer for one sample - capture, update, up to two divides, result.
// Owns the handshakes. Depends on wss_pkg.
module wss_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    input  wss_pkg::wss_status_t  status,
    output wss_pkg::wss_cmd_t     cmd
);
    import wss_pkg::*;

    typedef enum logic [6:0] {
        ST_IDLE   = 7'b0000001,
        ST_UPDATE = 7'b0000010,
        ST_WSTART = 7'b0000100,
        ST_WWAIT  = 7'b0001000,
        ST_OSTART = 7'b0010000,
        ST_OWAIT  = 7'b0100000,
        ST_EMIT   = 7'b1000000
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                cmd.update = 1'b1;
                state_next = ST_WSTART;
            end
            ST_WSTART:
            begin
                if (status.w_empty)
                begin
                    cmd.cap_w  = 1'b1;
                    state_next = ST_OSTART;
                end
                else
                begin
                    cmd.div_start_w = 1'b1;
                    state_next      = ST_WWAIT;
                end
            end
            ST_WWAIT:
            begin
                if (status.div_done)
                begin
                    cmd.cap_w  = 1'b1;
                    state_next = ST_OSTART;
                end
            end
            ST_OSTART:
            begin
                if (status.o_direct)
                begin
                    cmd.cap_o  = 1'b1;
                    state_next = ST_EMIT;
                end
                else
                begin
                    cmd.div_start_o = 1'b1;
                    state_next      = ST_OWAIT;
                end
            end
            ST_OWAIT:
            begin
                if (status.div_done)
                begin
                    cmd.cap_o  = 1'b1;
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_tvalid = out_valid_reg;

endmodule

@@ rtl/wss_dp.sv @@
`timescale 1ns / 1ps
// wss_dp: warmup gate, min/max, saturating totals, sample window ring and
// result register; holds the shared divider. Depends on wss_pkg, wss_div.
module wss_dp #(
    parameter int WINDOW_DEPTH = wss_pkg::WINDOW_DEPTH_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [wss_pkg::WARMUP_W-1:0]      cfg_wdata,
    input  logic [wss_pkg::SAMPLE_W-1:0]      sample_in,
    input  wss_pkg::wss_cmd_t                 cmd,
    output wss_pkg::wss_status_t              status,
    output logic [wss_pkg::OUT_TDATA_W-1:0]   out_data,
    output logic                              out_warm
);
    import wss_pkg::*;

    localparam int HEAD_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int FILL_W = $clog2(WINDOW_DEPTH + 1);
    localparam int WSUM_W = SAMPLE_W + FILL_W;

    logic [WARMUP_W-1:0] warmup_samples_reg;
    logic [SEEN_W-1:0]   warmup_seen_reg, warmup_seen_next;
    logic [COUNT_W-1:0]  kept_count_reg;
    logic [TOTAL_W-1:0]  total_sum_reg;
    logic [SAMPLE_W-1:0] low_mark_reg, high_mark_reg;
    logic [WSUM_W-1:0]   window_total_reg, window_total_next;
    logic [FILL_W-1:0]   window_fill_reg;
    logic [HEAD_W-1:0]   window_head_reg, window_head_next;

    logic [SAMPLE_W-1:0] sample_reg;
    logic [SAMPLE_W-1:0] evict_reg;
    logic                discard_reg;
    logic [SAMPLE_W-1:0] wmean_reg, omean_reg;
    logic [OUT_TDATA_W-1:0] out_data_reg;
    logic                out_warm_reg;

    logic [SAMPLE_W-1:0] window_mem [WINDOW_DEPTH];

    logic                keep;
    logic                window_full;
    logic [TOTAL_W:0]    total_add;
    logic                o_sat;

    logic                div_start;
    logic [DIV_W-1:0]    div_hi, div_lo, div_den;
    logic                div_done;
    logic [DIV_W-1:0]    div_q;

    always_comb
    begin
        warmup_seen_next = (warmup_seen_reg < SEEN_MAX) ?
                           warmup_seen_reg + SEEN_W'(1) : warmup_seen_reg;
        keep        = warmup_seen_next > SEEN_W'(warmup_samples_reg);
        window_full = window_fill_reg == FILL_W'(WINDOW_DEPTH);
        total_add   = {1'b0, total_sum_reg} + (TOTAL_W + 1)'(sample_reg);
        window_total_next = window_total_reg
                          - (window_full ? WSUM_W'(evict_reg) : WSUM_W'(0))
                          + WSUM_W'(sample_reg);
        window_head_next = (window_head_reg == HEAD_W'(WINDOW_DEPTH - 1)) ?
                           HEAD_W'(0) : window_head_reg + HEAD_W'(1);
        o_sat = total_sum_reg[TOTAL_W-1:COUNT_W] >= kept_count_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            warmup_samples_reg <= '0;
            warmup_seen_reg    <= '0;
            kept_count_reg     <= '0;
            total_sum_reg      <= '0;
            low_mark_reg       <= '0;
            high_mark_reg      <= '0;
            window_total_reg   <= '0;
            window_fill_reg    <= '0;
            window_head_reg    <= '0;
        end
        else
        begin
            if (cfg_we)
                warmup_samples_reg <= cfg_wdata;
            if (cmd.update)
            begin
                warmup_seen_reg <= warmup_seen_next;
                if (keep)
                begin
                    if (kept_count_reg == '0 || sample_reg < low_mark_reg)
                        low_mark_reg <= sample_reg;
                    if (sample_reg > high_mark_reg)
                        high_mark_reg <= sample_reg;
                    if (kept_count_reg != '1)
                        kept_count_reg <= kept_count_reg + COUNT_W'(1);
                    total_sum_reg <= total_add[TOTAL_W] ? '1 : total_add[TOTAL_W-1:0];
                    window_total_reg <= window_total_next;
                    if (!window_full)
                        window_fill_reg <= window_fill_reg + FILL_W'(1);
                    window_head_reg <= window_head_next;
                end
            end
        end
    end

    // sample ring: eviction read at capture, write at update, same slot
    always_ff @(posedge clk)
    begin
        if (cmd.update && keep)
            window_mem[window_head_reg] <= sample_reg;
        if (cmd.capture)
            evict_reg <= window_mem[window_head_reg];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
            sample_reg <= sample_in;
        if (cmd.update)
            discard_reg <= !keep;
        if (cmd.cap_w)
            wmean_reg <= status.w_empty ? '0 : div_q;
        if (cmd.cap_o)
            omean_reg <= (kept_count_reg == '0) ? '0 : (o_sat ? '1 : div_q);
        if (cmd.load_out)
        begin
            out_data_reg <= {high_mark_reg, low_mark_reg, omean_reg, wmean_reg};
            out_warm_reg <= discard_reg;
        end
    end

    always_comb
    begin
        div_start = cmd.div_start_w | cmd.div_start_o;
        if (cmd.div_start_w)
        begin
            div_hi  = DIV_W'(window_total_reg[WSUM_W-1:SAMPLE_W]);
            div_lo  = window_total_reg[SAMPLE_W-1:0];
            div_den = DIV_W'(window_fill_reg);
        end
        else
        begin
            div_hi  = total_sum_reg[TOTAL_W-1:COUNT_W];
            div_lo  = total_sum_reg[COUNT_W-1:0];
            div_den = kept_count_reg;
        end
    end

    wss_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .num_hi   (div_hi),
        .num_lo   (div_lo),
        .den      (div_den),
        .done     (div_done),
        .quotient (div_q)
    );

    always_comb
    begin
        status.w_empty  = window_fill_reg == '0;
        status.o_direct = (kept_count_reg == '0) || o_sat;
        status.div_done = div_done;
    end

    assign out_data = out_data_reg;
    assign out_warm = out_warm_reg;

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        window_fill_reg <= FILL_W'(WINDOW_DEPTH))
        else $error("window fill beyond depth");

    a_empty_sum: assert property (@(posedge clk) disable iff (!rst_n)
        (window_fill_reg == '0) |-> (window_total_reg == '0))
        else $error("empty window with non-zero total");

    a_min_max: assert property (@(posedge clk) disable iff (!rst_n)
        (kept_count_reg != '0) |-> (low_mark_reg <= high_mark_reg))
        else $error("minimum above maximum");

endmodule
